// ===== rtl/jxsrtp_pkg.sv =====
package jxsrtp_pkg;

	// payload header layout (codestream mode, T=1, K=0, I=00)
	localparam int unsigned HDR_BYTES     = 4;
	localparam int unsigned HDR_PHASE_W   = $clog2(HDR_BYTES);
	localparam int unsigned FCNT_W        = 5;
	localparam int unsigned PIDX_W        = 22;
	localparam int unsigned PCNT_W        = 11;
	localparam int unsigned CHUNK_W       = 16;
	localparam int unsigned FRAME_LEN_W   = 24;

	localparam logic [CHUNK_W-1:0] MPS_RESET   = 16'd1460;
	localparam logic [CHUNK_W-1:0] MPS_MIN     = 16'd5;
	localparam logic [CHUNK_W-1:0] HDR_LEN     = 16'd4;
	localparam logic [CHUNK_W-1:0] CHUNK_MIN   = 16'd1;
	localparam logic [CHUNK_W-1:0] CHUNK_RESET = MPS_RESET - HDR_LEN;

	// one classified input word on its way to the output side
	typedef struct packed {
		logic [7:0]  data;
		logic        has_hdr;
		logic        pkt_end;
		logic        mark;
		logic [31:0] hdr;
	} jxsrtp_entry_t;

	// header word {byte0, byte1, byte2, byte3}
	function automatic logic [31:0] jxsrtp_hdr(
		input logic              last,
		input logic [FCNT_W-1:0] f,
		input logic [PIDX_W-1:0] pidx
	);
		logic [PCNT_W-1:0] sep;
		logic [PCNT_W-1:0] p;
		sep = pidx[PIDX_W-1:PCNT_W];
		p   = pidx[PCNT_W-1:0];
		return {1'b1, 1'b0, last, 2'b00, f[4:2],
			f[1:0], sep[10:5],
			sep[4:0], p[10:8],
			p[7:0]};
	endfunction

endpackage

// ===== rtl/jxsrtp_front.sv =====
module jxsrtp_front import jxsrtp_pkg::*; #(
	parameter int unsigned FRAME_LENGTH_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CHUNK_W-1:0]     cfg_wr_data,
	input  logic                   in_take,
	input  logic [7:0]             data_byte,
	input  logic                   first_of_frame,
	input  logic [FRAME_LEN_W-1:0] frame_length,
	output logic                   q_push,
	output jxsrtp_entry_t          q_entry
);

	localparam int unsigned BR_W = FRAME_LENGTH_BITS;
	localparam int unsigned CW   = (BR_W > CHUNK_W) ? BR_W : CHUNK_W;

	logic [CHUNK_W-1:0] chunk_cap_q;
	logic [FCNT_W-1:0]  fcnt_q;
	logic [PIDX_W-1:0]  pidx_q;
	logic [BR_W-1:0]    br_q;
	logic [CHUNK_W-1:0] cbl_q;
	logic               ilp_q;

	logic [FCNT_W-1:0]  fcnt_cur;
	logic [PIDX_W-1:0]  pidx_cur;
	logic [BR_W-1:0]    br_cur;
	logic [CHUNK_W-1:0] cbl_cur;
	logic               ilp_cur;
	logic               live;
	logic               need_hdr;
	logic               take_all;
	logic [CHUNK_W-1:0] chunk;
	logic [CHUNK_W-1:0] cbl_use;
	logic               last_use;
	logic               pkt_end;
	logic [FCNT_W-1:0]  f_cur;

	// largest chunk per packet (payload size less header), clamped to at least one byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_cap_q <= CHUNK_RESET;
		end else if (cfg_wr_en) begin
			chunk_cap_q <= (cfg_wr_data < MPS_MIN) ? CHUNK_MIN : cfg_wr_data - HDR_LEN;
		end
	end

	// frame start resets the packet state
	always_comb begin
		fcnt_cur = first_of_frame ? fcnt_q + FCNT_W'(1) : fcnt_q;
		pidx_cur = first_of_frame ? '0 : pidx_q;
		br_cur   = first_of_frame ? BR_W'(frame_length) : br_q;
		cbl_cur  = first_of_frame ? '0 : cbl_q;
		ilp_cur  = first_of_frame ? 1'b0 : ilp_q;
	end

	// classify: drop, data only, or header plus data
	always_comb begin
		live     = (br_cur != '0);
		need_hdr = (cbl_cur == '0);
		take_all = (CW'(br_cur) <= CW'(chunk_cap_q));
		chunk    = take_all ? CHUNK_W'(br_cur) : chunk_cap_q;
		cbl_use  = need_hdr ? chunk : cbl_cur;
		last_use = need_hdr ? take_all : ilp_cur;
		pkt_end  = (cbl_use == CHUNK_MIN);
		f_cur    = fcnt_cur - FCNT_W'(1);
	end

	assign q_push          = in_take && live;
	assign q_entry.data    = data_byte;
	assign q_entry.has_hdr = need_hdr;
	assign q_entry.pkt_end = pkt_end;
	assign q_entry.mark    = last_use;
	assign q_entry.hdr     = jxsrtp_hdr(last_use, f_cur, pidx_cur);

	// state update per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcnt_q <= '0;
			pidx_q <= '0;
			br_q   <= '0;
			cbl_q  <= '0;
			ilp_q  <= 1'b0;
		end else if (in_take) begin
			fcnt_q <= fcnt_cur;
			if (live) begin
				pidx_q <= need_hdr ? pidx_cur + PIDX_W'(1) : pidx_cur;
				br_q   <= br_cur - BR_W'(1);
				cbl_q  <= cbl_use - CHUNK_MIN;
				ilp_q  <= pkt_end ? 1'b0 : last_use;
			end else begin
				pidx_q <= pidx_cur;
				br_q   <= br_cur;
				cbl_q  <= cbl_cur;
				ilp_q  <= ilp_cur;
			end
		end
	end

endmodule

// ===== rtl/jxsrtp_fifo.sv =====
module jxsrtp_fifo import jxsrtp_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  jxsrtp_entry_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output jxsrtp_entry_t rd_data,
	output logic          empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNTW = $clog2(DEPTH + 1);

	jxsrtp_entry_t   mem_q [DEPTH];
	logic [AW-1:0]   wptr_q;
	logic [AW-1:0]   rptr_q;
	logic [CNTW-1:0] cnt_q;
	logic            do_wr;
	logic            do_rd;

	assign full    = (cnt_q == CNTW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CNTW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CNTW'(1);
			end
		end
	end

endmodule

// ===== rtl/jxsrtp_back.sv =====
module jxsrtp_back import jxsrtp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  jxsrtp_entry_t q_head,
	output logic          q_pop,
	input  logic          pop,
	output logic          empty,
	output logic [7:0]    out_byte,
	output logic          packet_start,
	output logic          packet_end,
	output logic          marker,
	output logic          run_last
);

	jxsrtp_entry_t          cur_q;
	logic                   cur_v_q;
	logic [HDR_PHASE_W-1:0] phase_q;
	logic                   hdr_sent_q;
	logic                   out_v_q;

	logic                   out_free;
	logic                   load;
	logic                   is_data;
	logic [7:0]             nxt_byte;

	assign out_free = !out_v_q || pop;
	assign load     = out_free && cur_v_q;
	assign is_data  = !cur_q.has_hdr || hdr_sent_q;
	assign q_pop    = (!cur_v_q || (load && is_data)) && !q_empty;
	assign empty    = !out_v_q;

	// pick the header byte for this phase, or the data byte once the header is sent
	always_comb begin
		case (phase_q)
			2'd0:    nxt_byte = cur_q.hdr[31:24];
			2'd1:    nxt_byte = cur_q.hdr[23:16];
			2'd2:    nxt_byte = cur_q.hdr[15:8];
			2'd3:    nxt_byte = cur_q.hdr[7:0];
			default: nxt_byte = cur_q.hdr[7:0];
		endcase
		if (is_data) begin
			nxt_byte = cur_q.data;
		end
	end

	// current word and header phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q    <= 1'b0;
			phase_q    <= '0;
			hdr_sent_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_v_q    <= 1'b1;
				phase_q    <= '0;
				hdr_sent_q <= 1'b0;
			end else if (load && is_data) begin
				cur_v_q <= 1'b0;
			end else if (load) begin
				phase_q <= phase_q + HDR_PHASE_W'(1);
				if (phase_q == HDR_PHASE_W'(HDR_BYTES - 1)) begin
					hdr_sent_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= cur_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte     <= nxt_byte;
			packet_start <= !is_data && (phase_q == '0);
			packet_end   <= is_data && cur_q.pkt_end;
			marker       <= cur_q.mark;
			run_last     <= is_data;
		end
	end

endmodule

// ===== rtl/jpegxs_rtp_payload_packetizer.sv =====
// JPEG XS RTP payload packetizer, codestream mode.
// Input side is a queue write port: a frame byte is taken on a clock edge
// with push high and full low; first_of_frame marks a frame's first byte,
// which also carries frame_length. Bytes outside a frame are dropped.
// Output side is a queue read port: while empty is low the next word is on
// out_byte and its flags; pop takes it. Each packet's first data byte is
// preceded by four header bytes (T, L, F, SEP, P); marker flags the frame's
// last packet, run_last the final word caused by one input byte.
// The user must write the max payload size register (header included) through
// cfg_wr_en/cfg_wr_data while the block is idle; the block does not enforce this.
// A taken byte goes through the queue and current-word and output registers.
// Throughput: one output word per cycle while pop stays high; a packet of
// C bytes gives C+4 output words, so input sustains one byte per cycle
// between headers and may stall while a header goes out. The queue between
// classifier and serializer (QUEUE_DEPTH words) absorbs that burst.
// When pop stays low, the output register and queue fill, then full rises.
// Reset clears counters and queues; the register returns to 1460.
module jpegxs_rtp_payload_packetizer import jxsrtp_pkg::*; #(
	parameter int unsigned FRAME_LENGTH_BITS = 24,
	parameter int unsigned QUEUE_DEPTH       = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CHUNK_W-1:0]     cfg_wr_data,
	input  logic                   push,
	output logic                   full,
	input  logic [7:0]             data_byte,
	input  logic                   first_of_frame,
	input  logic [FRAME_LEN_W-1:0] frame_length,
	output logic                   empty,
	input  logic                   pop,
	output logic [7:0]             out_byte,
	output logic                   packet_start,
	output logic                   packet_end,
	output logic                   marker,
	output logic                   run_last
);

	logic          in_take;
	logic          q_push;
	jxsrtp_entry_t q_entry;
	logic          q_full;
	logic          q_pop;
	logic          q_empty;
	jxsrtp_entry_t q_head;

	assign full    = q_full;
	assign in_take = push && !q_full;

	jxsrtp_front #(
		.FRAME_LENGTH_BITS(FRAME_LENGTH_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_take        (in_take),
		.data_byte      (data_byte),
		.first_of_frame (first_of_frame),
		.frame_length   (frame_length),
		.q_push         (q_push),
		.q_entry        (q_entry)
	);

	jxsrtp_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_entry),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_head),
		.empty   (q_empty)
	);

	jxsrtp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.pop          (pop),
		.empty        (empty),
		.out_byte     (out_byte),
		.packet_start (packet_start),
		.packet_end   (packet_end),
		.marker       (marker),
		.run_last     (run_last)
	);

endmodule
